@@ rtl/wfg_pkg.sv @@
// shared types, constants and tables of the waveform function generator
package wfg_pkg;

    localparam int FracBits      = 16;
    localparam int SineIters     = 16;
    localparam int RegIndexWidth = 3;
    localparam int DataWidth     = 32;

    localparam logic signed [31:0] OneQ  = 32'sd65536;
    localparam logic signed [31:0] HalfQ = 32'sd32768;
    localparam logic signed [31:0] CordicGain = 32'sd652032874;

    // noise reduction: modulus, floor(2^40/10001) and ceil(2^45/10000)
    localparam logic [31:0] NoiseModulus    = 32'd10001;
    localparam logic [26:0] NoiseRecip      = 27'd109940168;
    localparam logic [31:0] NoiseScaleRecip = 32'd3518437209;

    // register indexes
    localparam logic [2:0] RegMode      = 3'd0;
    localparam logic [2:0] RegFrequency = 3'd1;
    localparam logic [2:0] RegPeriod    = 3'd2;
    localparam logic [2:0] RegAmplitude = 3'd3;
    localparam logic [2:0] RegPhase     = 3'd4;
    localparam logic [2:0] RegOffset    = 3'd5;
    localparam logic [2:0] RegSlope     = 3'd6;
    localparam logic [2:0] RegClamp     = 3'd7;

    // waveform kinds
    localparam logic [3:0] KindConst0 = 4'd0;
    localparam logic [3:0] KindSine   = 4'd1;
    localparam logic [3:0] KindSquare = 4'd2;
    localparam logic [3:0] KindRise   = 4'd3;
    localparam logic [3:0] KindFall   = 4'd4;
    localparam logic [3:0] KindTri    = 4'd5;
    localparam logic [3:0] KindNoise  = 4'd6;
    localparam logic [3:0] KindConst7 = 4'd7;
    localparam logic [3:0] KindRamp   = 4'd8;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_LOAD, OP_ACC, OP_PERIODS, OP_WHOLE, OP_PHASE, OP_VALUE,
        OP_CORDIC, OP_SINE_END, OP_RAMP, OP_SCALE, OP_FINISH
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic       done;
        logic       fail;
        logic [3:0] kind;
    } stat_t;

    // arctangent table in 2^32 per turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:  atan_turn = 32'd536870912;
            5'd1:  atan_turn = 32'd316933406;
            5'd2:  atan_turn = 32'd167458907;
            5'd3:  atan_turn = 32'd85004756;
            5'd4:  atan_turn = 32'd42667331;
            5'd5:  atan_turn = 32'd21354465;
            5'd6:  atan_turn = 32'd10679838;
            5'd7:  atan_turn = 32'd5340245;
            5'd8:  atan_turn = 32'd2670163;
            5'd9:  atan_turn = 32'd1335087;
            5'd10: atan_turn = 32'd667544;
            5'd11: atan_turn = 32'd333772;
            5'd12: atan_turn = 32'd166886;
            5'd13: atan_turn = 32'd83443;
            5'd14: atan_turn = 32'd41722;
            5'd15: atan_turn = 32'd20861;
            5'd16: atan_turn = 32'd10430;
            5'd17: atan_turn = 32'd5215;
            5'd18: atan_turn = 32'd2608;
            5'd19: atan_turn = 32'd1304;
            5'd20: atan_turn = 32'd652;
            5'd21: atan_turn = 32'd326;
            5'd22: atan_turn = 32'd163;
            5'd23: atan_turn = 32'd81;
            5'd24: atan_turn = 32'd41;
            default: atan_turn = 32'd0;
        endcase
    endfunction

endpackage

@@ rtl/wfg_datapath.sv @@
// arithmetic datapath: time, period, phase, waveform and scaling
module wfg_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic signed [31:0]     time_step,
    input  logic [31:0]            random_word,
    input  wfg_pkg::cmd_t          cmd,
    output wfg_pkg::stat_t         stat,
    output logic signed [31:0]     wave_value,
    output logic                   wave_ok
);

    logic [4:0]         mode_reg;
    logic signed [31:0] freq_reg, period_reg, amp_reg, phs_reg, ofs_reg, slope_reg, clamp_reg;
    logic signed [31:0] time_reg;

    // item operands
    logic signed [31:0] step_reg;
    logic [31:0]        rnd_reg;
    logic signed [33:0] acc_reg, shifted_reg;
    logic signed [64:0] prod_reg;
    logic signed [65:0] whole_reg;
    logic signed [35:0] phase_reg;
    logic signed [35:0] value_reg;
    logic               fail_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic signed [33:0] cz_reg;
    logic [4:0]         iter_reg;
    logic signed [31:0] out_reg;
    logic               ok_reg;
    logic               done_reg;

    logic [3:0] kind;
    assign kind = mode_reg[3:0];

    function automatic logic fits(input logic signed [65:0] v);
        fits = (v >= -66'sd2147483648) && (v <= 66'sd2147483647);
    endfunction

    // floor(a*b/2^F) with a up to 36 bits, as one signed 36x32 product
    logic signed [35:0] mq_a;
    logic signed [31:0] mq_b;
    logic signed [67:0] mq_full;
    logic signed [51:0] mq_res;
    assign mq_full = mq_a * mq_b;
    assign mq_res  = 52'(mq_full >>> wfg_pkg::FracBits);

    // whole periods times period length, signed
    logic signed [65:0] whole_prod;
    assign whole_prod = 66'($signed(prod_reg[33:0])) * 66'(period_reg);

    // noise value: (r mod 10001)*2^17/10000 rounded, by reciprocal multiplication
    logic [58:0] noise_prod1;
    logic [30:0] noise_num;
    logic [62:0] noise_prod2;
    logic [18:0] noise_q1_reg;
    logic [14:0] noise_r1_reg;
    logic [13:0] noise_r2_reg;
    logic [17:0] noise_q_reg;
    assign noise_prod1 = 59'(rnd_reg) * 59'(wfg_pkg::NoiseRecip);
    assign noise_num   = (31'(noise_r2_reg) << (wfg_pkg::FracBits + 1)) + 31'd5000;
    assign noise_prod2 = 63'(noise_num) * 63'(wfg_pkg::NoiseScaleRecip);

    logic signed [31:0] cdx, cdy;
    assign cdx = cy_reg >>> iter_reg;
    assign cdy = cx_reg >>> iter_reg;

    logic signed [31:0] wrapped;
    logic signed [31:0] zt;

    always_comb begin
        mq_a = 36'(acc_reg);
        mq_b = freq_reg;
        case (cmd.op)
            wfg_pkg::OP_PHASE: begin
                mq_a = 36'(shifted_reg - 34'(whole_reg));
                mq_b = freq_reg;
            end
            wfg_pkg::OP_RAMP: begin
                mq_a = 36'(acc_reg);
                mq_b = slope_reg;
            end
            wfg_pkg::OP_SCALE: begin
                mq_a = value_reg;
                mq_b = amp_reg;
            end
            default: ;
        endcase
        zt = phase_reg[31:0] <<< (32 - wfg_pkg::FracBits);
    end
    assign wrapped = 32'(acc_reg - 34'(whole_reg));

    // noise pipeline: quotient estimate, remainder, correction, scaling
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_q1_reg <= '0;
            noise_r1_reg <= '0;
            noise_r2_reg <= '0;
            noise_q_reg  <= '0;
        end else begin
            noise_q1_reg <= noise_prod1[58:40];
            noise_r1_reg <= 15'(rnd_reg - 32'(noise_q1_reg) * wfg_pkg::NoiseModulus);
            noise_r2_reg <= (noise_r1_reg >= 15'(wfg_pkg::NoiseModulus)) ?
                            14'(noise_r1_reg - 15'(wfg_pkg::NoiseModulus)) :
                            noise_r1_reg[13:0];
            noise_q_reg  <= noise_prod2[62:45];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            freq_reg   <= wfg_pkg::OneQ;
            period_reg <= wfg_pkg::OneQ;
            amp_reg    <= wfg_pkg::OneQ;
            phs_reg    <= '0;
            ofs_reg    <= '0;
            slope_reg  <= '0;
            clamp_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                wfg_pkg::RegMode:      mode_reg   <= cfg_data[4:0];
                wfg_pkg::RegFrequency: freq_reg   <= cfg_data;
                wfg_pkg::RegPeriod:    period_reg <= cfg_data;
                wfg_pkg::RegAmplitude: amp_reg    <= cfg_data;
                wfg_pkg::RegPhase:     phs_reg    <= cfg_data;
                wfg_pkg::RegOffset:    ofs_reg    <= cfg_data;
                wfg_pkg::RegSlope:     slope_reg  <= cfg_data;
                wfg_pkg::RegClamp:     clamp_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // operation sequencing of the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            fail_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else if (cmd.start) begin
            done_reg <= (cmd.op == wfg_pkg::OP_FINISH);
            case (cmd.op)
                wfg_pkg::OP_LOAD: begin
                    step_reg <= time_step;
                    rnd_reg  <= random_word;
                    fail_reg <= (freq_reg == 32'sd0);
                    value_reg <= '0;
                end
                wfg_pkg::OP_ACC: begin
                    acc_reg     <= 34'(time_reg) + 34'(step_reg);
                    shifted_reg <= 34'(time_reg) + 34'(step_reg) + 34'(phs_reg);
                    if (!fits(66'(34'(time_reg) + 34'(step_reg))) ||
                        !fits(66'(34'(time_reg) + 34'(step_reg) + 34'(phs_reg))))
                        fail_reg <= 1'b1;
                end
                wfg_pkg::OP_PERIODS: begin
                    prod_reg <= 65'(acc_reg * freq_reg) >>> (2 * wfg_pkg::FracBits);
                end
                wfg_pkg::OP_WHOLE: begin
                    if (period_reg == 32'sd0) begin
                        whole_reg <= '0;
                    end else begin
                        whole_reg <= whole_prod;
                        if (prod_reg > 65'sd4294967295 || prod_reg < -65'sd4294967295)
                            fail_reg <= 1'b1;
                        else if (!fits(whole_prod))
                            fail_reg <= 1'b1;
                    end
                end
                wfg_pkg::OP_PHASE: begin
                    phase_reg <= 36'(mq_res);
                    if (!fits(66'(mq_res))) fail_reg <= 1'b1;
                end
                wfg_pkg::OP_VALUE: begin
                    case (kind)
                        wfg_pkg::KindSine: begin
                            cx_reg <= wfg_pkg::CordicGain;
                            cy_reg <= '0;
                            iter_reg <= '0;
                            if (zt > 32'sd1073741824)
                                cz_reg <= 34'sd2147483648 - 34'(zt);
                            else if (zt < -32'sd1073741824)
                                cz_reg <= -34'sd2147483648 - 34'(zt);
                            else
                                cz_reg <= 34'(zt);
                        end
                        wfg_pkg::KindSquare:
                            value_reg <= (phase_reg < 36'(wfg_pkg::HalfQ)) ?
                                36'(wfg_pkg::OneQ) : -36'(wfg_pkg::OneQ);
                        wfg_pkg::KindRise: value_reg <= phase_reg - 36'(wfg_pkg::HalfQ);
                        wfg_pkg::KindFall: value_reg <= 36'(wfg_pkg::HalfQ) - phase_reg;
                        wfg_pkg::KindTri:
                            value_reg <= (phase_reg < 36'(wfg_pkg::HalfQ)) ?
                                (phase_reg <<< 1) - 36'(wfg_pkg::HalfQ) :
                                36'(3 * wfg_pkg::HalfQ) - (phase_reg <<< 1);
                        wfg_pkg::KindNoise:
                            value_reg <= 36'(noise_q_reg) - 36'(wfg_pkg::OneQ);
                        default: value_reg <= '0;
                    endcase
                end
                wfg_pkg::OP_CORDIC: begin
                    if (cz_reg >= 0) begin
                        cx_reg <= cx_reg - cdx;
                        cy_reg <= cy_reg + cdy;
                        cz_reg <= cz_reg - 34'(wfg_pkg::atan_turn(iter_reg));
                    end else begin
                        cx_reg <= cx_reg + cdx;
                        cy_reg <= cy_reg - cdy;
                        cz_reg <= cz_reg + 34'(wfg_pkg::atan_turn(iter_reg));
                    end
                    iter_reg <= iter_reg + 5'd1;
                end
                wfg_pkg::OP_SINE_END:
                    value_reg <= 36'(cy_reg >>> (30 - wfg_pkg::FracBits));
                wfg_pkg::OP_RAMP: begin
                    if (mode_reg[4] && ((slope_reg < 0 && 52'(mq_res) + 52'(ofs_reg) < 52'(clamp_reg)) ||
                                        (slope_reg > 0 && 52'(mq_res) + 52'(ofs_reg) >= 52'(clamp_reg))))
                        value_reg <= 36'(clamp_reg);
                    else begin
                        value_reg <= 36'(mq_res + 52'(ofs_reg));
                        if (!fits(66'(mq_res + 52'(ofs_reg)))) fail_reg <= 1'b1;
                    end
                end
                wfg_pkg::OP_SCALE: begin
                    value_reg <= 36'(mq_res + 52'(ofs_reg));
                    if (!fits(66'(mq_res + 52'(ofs_reg)))) fail_reg <= 1'b1;
                end
                wfg_pkg::OP_FINISH: begin
                    if (kind == wfg_pkg::KindConst0 || kind == wfg_pkg::KindConst7) begin
                        out_reg <= ofs_reg;
                        ok_reg  <= 1'b1;
                    end else if (fail_reg) begin
                        out_reg <= '0;
                        ok_reg  <= 1'b0;
                    end else if (kind >= wfg_pkg::KindSine && kind <= wfg_pkg::KindTri &&
                                 acc_reg > 34'(period_reg)) begin
                        if (!fits(66'(acc_reg - 34'(whole_reg)))) begin
                            out_reg <= '0;
                            ok_reg  <= 1'b0;
                        end else begin
                            time_reg <= wrapped;
                            out_reg  <= value_reg[31:0];
                            ok_reg   <= 1'b1;
                        end
                    end else begin
                        time_reg <= acc_reg[31:0];
                        out_reg  <= value_reg[31:0];
                        ok_reg   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign stat.done = done_reg;
    assign stat.fail = fail_reg;
    assign stat.kind = kind;
    assign wave_value = out_reg;
    assign wave_ok    = ok_reg;

endmodule

@@ rtl/wfg_controller.sv @@
// controller state machine: steps the datapath and handles the handshakes
module wfg_controller (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output wfg_pkg::cmd_t  cmd,
    input  wfg_pkg::stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ACC, ST_PERIODS, ST_WHOLE, ST_PHASE, ST_VALUE,
        ST_CORDIC, ST_SINE_END, ST_SCALE, ST_FINISH, ST_WAIT, ST_OUT
    } state_t;

    state_t     state_reg;
    logic [4:0] cnt_reg;
    logic       valid_reg;

    // state, iteration count and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_FINISH) valid_reg <= 1'b1;
            else if (valid_reg && m_tready) valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:     if (s_tvalid) state_reg <= ST_ACC;
                ST_ACC:      state_reg <= ST_PERIODS;
                ST_PERIODS:  state_reg <= ST_WHOLE;
                ST_WHOLE:    state_reg <= ST_PHASE;
                ST_PHASE:    state_reg <= ST_VALUE;
                ST_VALUE: begin
                    cnt_reg <= '0;
                    state_reg <= (stat.kind == wfg_pkg::KindSine) ? ST_CORDIC : ST_SCALE;
                end
                ST_CORDIC: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(wfg_pkg::SineIters - 1)) state_reg <= ST_SINE_END;
                end
                ST_SINE_END: state_reg <= ST_SCALE;
                ST_SCALE:    state_reg <= ST_WAIT;
                // hold the finishing step while the last result is still waiting
                ST_WAIT:     if (!valid_reg || m_tready) state_reg <= ST_FINISH;
                ST_FINISH:   state_reg <= ST_IDLE;
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        cmd.start = 1'b1;
        cmd.op    = wfg_pkg::OP_LOAD;
        unique case (state_reg)
            ST_IDLE:     cmd.start = s_tvalid;
            ST_ACC:      cmd.op = wfg_pkg::OP_ACC;
            ST_PERIODS:  cmd.op = wfg_pkg::OP_PERIODS;
            ST_WHOLE:    cmd.op = wfg_pkg::OP_WHOLE;
            ST_PHASE:    cmd.op = wfg_pkg::OP_PHASE;
            ST_VALUE:    cmd.op = wfg_pkg::OP_VALUE;
            ST_CORDIC:   cmd.op = wfg_pkg::OP_CORDIC;
            ST_SINE_END: cmd.op = wfg_pkg::OP_SINE_END;
            ST_SCALE:    cmd.op = (stat.kind == wfg_pkg::KindRamp) ?
                                  wfg_pkg::OP_RAMP : wfg_pkg::OP_SCALE;
            ST_FINISH:   cmd.op = wfg_pkg::OP_FINISH;
            default:     cmd.start = 1'b0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    // result is produced only after the finishing step
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> $past(state_reg == ST_FINISH)) else $error("unexpected done");
    // cordic loop runs inside its count
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CORDIC |-> cnt_reg < 5'(wfg_pkg::SineIters)) else $error("count");
    // no request accepted while busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready) else $error("ready while busy");

endmodule

@@ rtl/waveform_function_generator.sv @@
// top level of the waveform function generator
// One request at a time: the result becomes valid when the finishing step
// completes, and the next request can be taken in that same cycle; the sine adds
// 16 CORDIC rotations, one per cycle on a shared unit, and a final shift. The
// noise reduction runs alongside the first four steps. A result still held by
// m_tready low stalls the finishing step, so the output register is never
// overwritten before it is taken.
module waveform_function_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // time_step [31:0], random_word [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // wave_value [31:0], ok [32], zero fill
);

    wfg_pkg::cmd_t  cmd;
    wfg_pkg::stat_t stat;
    logic signed [31:0] wave_value;
    logic               wave_ok;

    wfg_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd), .stat(stat)
    );

    wfg_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .time_step(s_tdata[31:0]), .random_word(s_tdata[63:32]),
        .cmd(cmd), .stat(stat), .wave_value(wave_value), .wave_ok(wave_ok)
    );

    assign m_tdata = {7'd0, wave_ok, wave_value};

endmodule
